[rtl/bobg_pkg.sv]
// Shared types, constants and helpers for the bosonic occupation basis generator.
package bobg_pkg;

    localparam int MAX_PARTICLES  = 16;
    localparam int MAX_SITES      = 8;
    localparam int COUNT_BITS     = 5;
    localparam int POS_BITS       = 4;
    localparam int PIDX_BITS      = $clog2(MAX_PARTICLES);
    localparam int INDEX_BITS     = 18;
    localparam int PC_BITS        = 5;
    localparam int SC_BITS        = 4;
    localparam int OCC_BITS       = MAX_SITES * COUNT_BITS;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 5;

    localparam logic [PC_BITS-1:0] PARTICLE_COUNT_RESET = PC_BITS'(2);
    localparam logic [SC_BITS-1:0] SITE_COUNT_RESET     = SC_BITS'(2);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PARTICLE_COUNT,
        REG_SITE_COUNT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PHASE_SWEEP,
        PHASE_DONE
    } phase_t;

    typedef struct packed {
        logic [MAX_PARTICLES-1:0][POS_BITS-1:0] positions;
        logic [POS_BITS-1:0]                    sweep_offset;
        logic [INDEX_BITS-1:0]                  emitted_count;
        phase_t                                 phase;
    } state_t;

    typedef struct packed {
        logic [OCC_BITS-1:0]   occupations;
        logic [INDEX_BITS-1:0] vector_index;
        logic                  last;
        logic                  exhausted;
    } result_t;

    function automatic state_t init_state();
        state_t s;
        for (int k = 0; k < MAX_PARTICLES; k++)
        begin
            s.positions[k] = POS_BITS'(1);
        end
        s.sweep_offset  = '0;
        s.emitted_count = '0;
        s.phase         = PHASE_SWEEP;
        return s;
    endfunction

endpackage

[rtl/bobg_if.sv]
// Valid/ready channel interfaces: request, result and configuration write.
interface bobg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface bobg_res_if;
    logic                              valid;
    logic                              ready;
    logic [bobg_pkg::OCC_BITS-1:0]     occupations;
    logic [bobg_pkg::INDEX_BITS-1:0]   vector_index;
    logic                              last;
    logic                              exhausted;

    modport source (output valid, output occupations, output vector_index,
                    output last, output exhausted, input ready);
    modport sink   (input valid, input occupations, input vector_index,
                    input last, input exhausted, output ready);
endinterface

interface bobg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bobg_pkg::CFG_INDEX_BITS-1:0] index;
    logic [bobg_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bobg_step.sv]
// One enumeration step: occupation histogram of the current vector and its successor.
module bobg_step (
    input  bobg_pkg::state_t                 cur,
    input  logic                             restart,
    input  logic [bobg_pkg::PC_BITS-1:0]     particle_count,
    input  logic [bobg_pkg::SC_BITS-1:0]     site_count,
    output bobg_pkg::result_t                res,
    output bobg_pkg::state_t                 nxt
);
    import bobg_pkg::*;

    state_t                                  base;
    logic                                    cfg_ok;
    logic                                    sweeping;
    logic [OCC_BITS-1:0]                     occ;
    logic [PIDX_BITS-1:0]                    top_idx;
    logic                                    last_vec;
    logic                                    sweep_wrap;
    logic [MAX_PARTICLES-1:0]                below;
    logic [POS_BITS-1:0]                     carry_val;
    logic [MAX_PARTICLES-1:0][POS_BITS-1:0]  adv_pos;
    state_t                                  adv;

    // restart applies before the vector is read out
    assign base   = restart ? init_state() : cur;
    assign cfg_ok = (particle_count >= PC_BITS'(2))
                 && (particle_count <= PC_BITS'(MAX_PARTICLES))
                 && (site_count >= SC_BITS'(1))
                 && (site_count <= SC_BITS'(MAX_SITES));
    assign sweeping = cfg_ok && (base.phase == PHASE_SWEEP);

    // histogram of the fixed positions plus the sweeping particle
    always_comb
    begin
        logic [COUNT_BITS-1:0] cnt;
        occ = '0;
        for (int s = 0; s < MAX_SITES; s++)
        begin
            cnt = '0;
            for (int k = 0; k < MAX_PARTICLES; k++)
            begin
                if ((PC_BITS'(k) + PC_BITS'(1) < particle_count)
                    && (base.positions[k] == POS_BITS'(s + 1)))
                    cnt = cnt + COUNT_BITS'(1);
            end
            if (base.sweep_offset == POS_BITS'(s))
                cnt = cnt + COUNT_BITS'(1);
            if (SC_BITS'(s) < site_count)
                occ[s*COUNT_BITS +: COUNT_BITS] = cnt;
        end
    end

    assign top_idx  = PIDX_BITS'(particle_count - PC_BITS'(2));
    assign last_vec = base.positions[top_idx] >= POS_BITS'(site_count);

    assign sweep_wrap = ({1'b0, base.sweep_offset} + 5'd1) >= {1'b0, site_count};

    // carry: every leading entry sitting on the top site rolls over to the
    // first entry below the top, incremented
    always_comb
    begin
        below[0]  = 1'b1;
        for (int k = 1; k < MAX_PARTICLES; k++)
        begin
            below[k] = below[k-1] && (base.positions[k-1] == POS_BITS'(site_count));
        end
        carry_val = '0;
        for (int k = 0; k < MAX_PARTICLES; k++)
        begin
            if (below[k] && (base.positions[k] != POS_BITS'(site_count)))
                carry_val = base.positions[k] + POS_BITS'(1);
        end
        for (int k = 0; k < MAX_PARTICLES; k++)
        begin
            adv_pos[k] = below[k] ? carry_val : base.positions[k];
        end
    end

    always_comb
    begin
        adv               = base;
        adv.emitted_count = base.emitted_count + INDEX_BITS'(1);
        if (last_vec)
        begin
            adv.phase = PHASE_DONE;
        end
        else if (!sweep_wrap)
        begin
            adv.sweep_offset = base.sweep_offset + POS_BITS'(1);
        end
        else
        begin
            adv.positions    = adv_pos;
            adv.sweep_offset = carry_val - POS_BITS'(1);
        end
    end

    always_comb
    begin
        if (sweeping)
        begin
            res.occupations  = occ;
            res.vector_index = base.emitted_count;
            res.last         = last_vec;
            res.exhausted    = 1'b0;
            nxt              = adv;
        end
        else
        begin
            res.occupations  = '0;
            res.vector_index = '0;
            res.last         = 1'b0;
            res.exhausted    = 1'b1;
            nxt              = base;
        end
    end

endmodule

[rtl/bosonic_occupation_basis_generator.sv]
// Top level: enumerates bosonic occupation vectors, one per request beat.
// Results are registered in a two-entry output buffer (main, skid) that keeps
// requests flowing while a result waits. Throughput: one vector per cycle while the
// skid slot is empty; the successor and histogram are one combinational step.
// Reset: particle_count = 2, site_count = 2, enumeration at its first vector,
// output buffer empty. A configuration write restarts the enumeration.
module bosonic_occupation_basis_generator (
    input  logic         clk,
    input  logic         rst_n,
    bobg_req_if.sink     req,
    bobg_res_if.source   res,
    bobg_cfg_if.sink     cfg
);
    import bobg_pkg::*;

    // configuration and enumeration state
    logic [PC_BITS-1:0] particle_count_reg;
    logic [SC_BITS-1:0] site_count_reg;
    state_t             state_reg;
    state_t             state_next;

    // result buffer: main drives the port, skid holds a second beat
    result_t            main_reg;
    logic               main_valid_reg;
    result_t            skid_reg;
    logic               skid_valid_reg;

    result_t            step_res;
    logic               req_accept;
    logic               res_take;
    logic               main_free;
    logic               cfg_write;

    assign cfg.ready  = 1'b1;
    assign cfg_write  = cfg.valid && cfg.ready;

    // accept whenever the skid slot is empty
    assign req.ready  = !skid_valid_reg;
    assign req_accept = req.valid && req.ready;

    assign res.valid        = main_valid_reg;
    assign res.occupations  = main_reg.occupations;
    assign res.vector_index = main_reg.vector_index;
    assign res.last         = main_reg.last;
    assign res.exhausted    = main_reg.exhausted;
    assign res_take         = main_valid_reg && res.ready;
    assign main_free        = !main_valid_reg || res_take;

    bobg_step u_step (
        .cur            (state_reg),
        .restart        (req.restart),
        .particle_count (particle_count_reg),
        .site_count     (site_count_reg),
        .res            (step_res),
        .nxt            (state_next)
    );

    // configuration registers; any write to a known register restarts the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            particle_count_reg <= PARTICLE_COUNT_RESET;
            site_count_reg     <= SITE_COUNT_RESET;
            state_reg          <= init_state();
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_PARTICLE_COUNT: particle_count_reg <= cfg.data[PC_BITS-1:0];
                REG_SITE_COUNT:     site_count_reg     <= cfg.data[SC_BITS-1:0];
            endcase
            state_reg <= init_state();
        end
        else if (req_accept)
        begin
            state_reg <= state_next;
        end
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (main_free)
            begin
                // refill main from skid first, then from a new beat
                main_valid_reg <= skid_valid_reg || req_accept;
                skid_valid_reg <= 1'b0;
            end
            else if (req_accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (req_accept)
                main_reg <= step_res;
        end
        else if (req_accept)
        begin
            skid_reg <= step_res;
        end
    end

endmodule

[tb/sv/basis_vector_checker.sv]
// Checker for the occupation basis generator: tracks the enumeration, predicts each vector, compares.
module basis_vector_checker
(
    input  logic       clk,
    input  logic       rst_n,
    bobg_req_if        req,
    bobg_res_if        res,
    bobg_cfg_if        cfg,
    output int         failures,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bobg_pkg::*;

    // Configuration and enumeration state as the block should hold it
    logic [PC_BITS-1:0]    n_particles;
    logic [SC_BITS-1:0]    n_sites;
    int                    site_of [MAX_PARTICLES];
    int                    sweep_site;
    logic [INDEX_BITS-1:0] ordinal;
    phase_t                stage;

    result_t               expected_vectors [$];
    result_t               want;

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    function automatic void rewind();
        for (int k = 0; k < MAX_PARTICLES; k++)
        begin
            site_of[k] = 1;
        end
        sweep_site = 0;
        ordinal    = '0;
        stage      = PHASE_SWEEP;
    endfunction

    function automatic bit shape_ok();
        return n_particles >= 2 && n_particles <= MAX_PARTICLES &&
               n_sites >= 1 && n_sites <= MAX_SITES;
    endfunction

    // Move the sweeping particle, or carry through the stacked positions
    function automatic void step_forward(int n, int m);
        if (sweep_site + 1 < m)
        begin
            sweep_site++;
            return;
        end
        site_of[0]++;
        for (int r = 0; r + 2 < n; r++)
        begin
            if (site_of[r] >= m + 1)
            begin
                site_of[r + 1]++;
                for (int i = 0; i <= r; i++)
                begin
                    site_of[i] = site_of[r + 1];
                end
            end
        end
        sweep_site = site_of[0] - 1;
    endfunction

    function automatic result_t predict_vector(logic restart_req);
        result_t v;
        int      hist [MAX_SITES];
        int      n;
        int      m;
        int      s;
        bit      fin;
        n = n_particles;
        m = n_sites;
        v = '0;
        if (restart_req)
        begin
            rewind();
        end
        if (!shape_ok() || stage != PHASE_SWEEP)
        begin
            v.exhausted = 1'b1;
            return v;
        end
        for (int k = 0; k < MAX_SITES; k++)
        begin
            hist[k] = 0;
        end
        for (int k = 0; k + 1 < n; k++)
        begin
            s = site_of[k] - 1;
            if (site_of[k] >= 1 && s < m)
            begin
                hist[s]++;
            end
        end
        if (sweep_site < m)
        begin
            hist[sweep_site]++;
        end
        for (s = 0; s < m; s++)
        begin
            v.occupations[s * COUNT_BITS +: COUNT_BITS] = COUNT_BITS'(hist[s]);
        end
        fin = site_of[n - 2] >= m;
        v.vector_index = ordinal;
        v.last         = fin;
        ordinal        = ordinal + 1'b1;
        if (fin)
        begin
            stage = PHASE_DONE;
        end
        else
        begin
            step_forward(n, m);
        end
        return v;
    endfunction

    function automatic void check_field(string field, logic [63:0] exp_val,
                                        logic [63:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t %s mismatch: expected %0h actual %0h",
                     $time, field, exp_val, got_val);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_particles = PARTICLE_COUNT_RESET;
            n_sites     = SITE_COUNT_RESET;
            rewind();
            expected_vectors.delete();
        end
        else
        begin
            // Compare the result beat first: it can only belong to an older request
            if (res.valid && res.ready)
            begin
                if (expected_vectors.size() == 0)
                begin
                    $display("%0t unexpected result beat: expected none actual %0h",
                             $time, res.occupations);
                    failures++;
                end
                else
                begin
                    want = expected_vectors.pop_front();
                    check_field("occupations", 64'(want.occupations),
                                64'(res.occupations));
                    check_field("vector_index", 64'(want.vector_index),
                                64'(res.vector_index));
                    check_field("last", 64'(want.last), 64'(res.last));
                    check_field("exhausted", 64'(want.exhausted), 64'(res.exhausted));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_PARTICLE_COUNT)
                begin
                    n_particles = cfg.data[PC_BITS-1:0];
                end
                else
                begin
                    n_sites = cfg.data[SC_BITS-1:0];
                end
                rewind();
            end
            if (req.valid && req.ready)
            begin
                expected_vectors.push_back(predict_vector(req.restart));
            end
        end
        pending = expected_vectors.size();
    end

endmodule

[tb/sv/testbench.sv]
// Top of the occupation basis generator bench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bobg_pkg::*;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    bit   calm;
    int   random_items;
    int   roll;
    int   burst;

    // Shapes that the block must refuse: N too small or too large, M zero or too large
    logic [CFG_DATA_BITS-1:0] bad_n [7] = '{31, 0, 1, 17, 2, 2, 2};
    logic [CFG_DATA_BITS-1:0] bad_m [7] = '{2, 2, 2, 2, 0, 9, 31};

    bobg_req_if req_ch ();
    bobg_res_if res_ch ();
    bobg_cfg_if cfg_ch ();

    bosonic_occupation_basis_generator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    basis_vector_checker i_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .res      (res_ch),
        .cfg      (cfg_ch),
        .failures (failures),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Hard stop in case the block hangs on a handshake
    initial
    begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

    // Result side: drop ready now and then, hold it high during the calm stretch
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    // Drive one register write beat; leave valid high so back-to-back writes
    // need only one assignment per step. The caller lowers valid.
    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= which;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Write both N and M, in random order, then close the write channel
    task automatic set_shape(input logic [CFG_DATA_BITS-1:0] n,
                             input logic [CFG_DATA_BITS-1:0] m);
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_PARTICLE_COUNT, n);
            write_reg(REG_SITE_COUNT, m);
        end
        else
        begin
            write_reg(REG_SITE_COUNT, m);
            write_reg(REG_PARTICLE_COUNT, n);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold off until every predicted vector has come back
    task automatic drain();
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Send one request beat. Occasionally pause until the block is empty,
    // otherwise insert random idle cycles unless in the calm stretch.
    task automatic push_request(input logic rs);
        if (!calm && $urandom_range(0, 59) == 0)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
            drain();
        end
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= rs;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        calm           = 1'b0;
        random_items   = 0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_PARTICLE_COUNT;
        cfg_ch.data    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset shape (two particles, two sites): walk to the end, run past it,
        // then restart after exhaustion
        repeat (4) push_request(1'b0);
        push_request(1'b1);
        req_ch.valid <= 1'b0;

        // Largest shape: all sixteen particles stacked on site zero first
        drain();
        set_shape(16, 8);
        push_request(1'b1);
        push_request(1'b0);
        push_request(1'b0);
        req_ch.valid <= 1'b0;

        // Refused shapes answer every request as exhausted
        for (int k = 0; k < 7; k++)
        begin
            drain();
            set_shape(bad_n[k], bad_m[k]);
            push_request(1'b0);
            req_ch.valid <= 1'b0;
        end

        // Single site: the first vector is already the last one
        drain();
        set_shape(16, 1);
        push_request(1'b0);
        push_request(1'b0);
        req_ch.valid <= 1'b0;

        // Two particles on eight sites, restart in the middle of a sweep
        drain();
        set_shape(2, 8);
        push_request(1'b0);
        push_request(1'b1);
        push_request(1'b0);
        req_ch.valid <= 1'b0;

        // Random phases: mostly small shapes whose whole basis often fits in one burst,
        // so last and exhausted come up often; some large and some raw writes
        while (random_items < 1500)
        begin
            drain();
            calm = random_items >= 500 && random_items < 800;
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                set_shape(CFG_DATA_BITS'($urandom_range(2, 5)),
                          CFG_DATA_BITS'($urandom_range(1, 4)));
                burst = $urandom_range(4, 70);
            end
            else if (roll < 80)
            begin
                set_shape(CFG_DATA_BITS'($urandom_range(2, 16)),
                          CFG_DATA_BITS'($urandom_range(1, 8)));
                burst = $urandom_range(4, 40);
            end
            else if (roll < 88)
            begin
                set_shape($urandom_range(0, 1) ? CFG_DATA_BITS'(16)
                                               : CFG_DATA_BITS'($urandom_range(2, 16)),
                          CFG_DATA_BITS'(8));
                burst = $urandom_range(4, 30);
            end
            else
            begin
                // Raw write: any index, any data, valid or not
                write_reg(cfg_reg_t'($urandom_range(0, 1)),
                          CFG_DATA_BITS'($urandom_range(0, 31)));
                cfg_ch.valid <= 1'b0;
                burst = $urandom_range(2, 40);
            end
            repeat (burst)
            begin
                push_request($urandom_range(0, 99) < 4);
                random_items++;
            end
            req_ch.valid <= 1'b0;
        end

        // Let the last vectors come out, then give the verdict
        calm = 1'b0;
        drain();
        repeat (4) @(negedge clk);
        if (failures == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bobg_pkg.sv
rtl/bobg_if.sv
rtl/bobg_step.sv
rtl/bosonic_occupation_basis_generator.sv
tb/sv/basis_vector_checker.sv
tb/sv/testbench.sv
